// ===== design/assert_macros.svh =====
// assertion macros used by the top-level design file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is asserted (active low)
`define HFSL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked property checked during reset as well
`define HFSL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== design/hfsl_pkg.sv =====
// shared constants and codes for the frequency-sorted table
// no dependencies
package hfsl_pkg;

    localparam int DEF_MAX_ENTRIES = 512;
    localparam int DEF_FREQ_BITS   = 32;

    localparam int SYM_W       = 8;
    localparam int PORT_FREQ_W = 32;
    localparam int HELD_W      = 10;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // commands
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TAKE = 1'b1;

    // result status
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FEW  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPECIAL_SYMBOL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARKER_FREQUENCY = 2'd1;

    // head pointer operations of the ring store
    localparam int HOP_W = 2;
    localparam logic [HOP_W-1:0] HOP_HOLD = 2'd0;
    localparam logic [HOP_W-1:0] HOP_BACK = 2'd1;
    localparam logic [HOP_W-1:0] HOP_ADV2 = 2'd2;

endpackage

// ===== design/hfsl_ring.sv =====
// ring store of table entries addressed by position from the head
// depends on hfsl_pkg
module hfsl_ring #(
    parameter int MAX_ENTRIES = hfsl_pkg::DEF_MAX_ENTRIES,
    parameter int ENTRY_W     = hfsl_pkg::SYM_W + 1 + hfsl_pkg::DEF_FREQ_BITS,
    localparam int AW         = $clog2(MAX_ENTRIES)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [hfsl_pkg::HOP_W-1:0] i_head_op,
    input  logic                       i_rd_en,
    input  logic [AW-1:0]              i_rd_idx,
    output logic [ENTRY_W-1:0]         o_rd_data,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_idx,
    input  logic [ENTRY_W-1:0]         i_wr_data
);
    import hfsl_pkg::*;

    localparam logic [AW:0] DEPTH = (AW+1)'(MAX_ENTRIES);

    logic [ENTRY_W-1:0] mem [MAX_ENTRIES];
    logic [AW-1:0]      r_head;
    logic [AW-1:0]      n_head;
    logic [ENTRY_W-1:0] r_rd_data;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic [AW:0]        adv_sum;

    // position plus head, one wrap at most
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH) begin
            s = s - DEPTH;
        end
        return s[AW-1:0];
    endfunction

    assign rd_addr = wrap_add(r_head, i_rd_idx);
    assign wr_addr = wrap_add(r_head, i_wr_idx);
    assign adv_sum = {1'b0, r_head} + (AW+1)'(2);

    always_comb begin
        n_head = r_head;
        case (i_head_op)
            HOP_HOLD: n_head = r_head;
            HOP_BACK: begin
                if (r_head == '0) begin
                    n_head = AW'(MAX_ENTRIES - 1);
                end else begin
                    n_head = r_head - AW'(1);
                end
            end
            HOP_ADV2: begin
                if (adv_sum >= DEPTH) begin
                    n_head = AW'(adv_sum - DEPTH);
                end else begin
                    n_head = adv_sum[AW-1:0];
                end
            end
            default: n_head = r_head;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
        end else begin
            r_head <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/huffman_frequency_sorted_list.sv =====
// frequency-sorted entry table for huffman tree building, top level
// depends on hfsl_pkg, hfsl_ring and assert_macros.svh
//
//  channel   | handshake                          | payload
//  ----------+------------------------------------+------------------------------------
//  command   | start in, busy out                 | i_cmd, i_symbol, i_frequency
//  result    | o_done strobe, one cycle, no stall | o_status, o_entry_*, o_first_*,
//            |                                    | o_second_*, o_entries_held
//  config    | i_cfg_valid in, o_cfg_ready out    | i_cfg_index, i_cfg_data
//
// an item is taken when start is high and busy is low; o_done pulses in the cycle
// after the item finishes. an add walks the table from the head through the
// single read port of the ring store, one entry a cycle (merged entries and an
// empty table skip this walk), then, unless a new entry finds the table full,
// moves the entry tailward, again one entry a cycle. take-two reads the two head entries.
// no clearing pass after reset: only positions below the count are ever read.
// the result side cannot stall, results are simply presented and dropped.
`include "assert_macros.svh"

module huffman_frequency_sorted_list #(
    parameter int MAX_ENTRIES = hfsl_pkg::DEF_MAX_ENTRIES,
    parameter int FREQ_BITS   = hfsl_pkg::DEF_FREQ_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // command item
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_cmd,
    input  logic [hfsl_pkg::SYM_W-1:0]       i_symbol,
    input  logic [hfsl_pkg::PORT_FREQ_W-1:0] i_frequency,
    // result item
    output logic                             o_done,
    output logic [hfsl_pkg::STATUS_W-1:0]    o_status,
    output logic [hfsl_pkg::SYM_W-1:0]       o_entry_symbol,
    output logic [hfsl_pkg::PORT_FREQ_W-1:0] o_entry_frequency,
    output logic                             o_entry_is_leaf,
    output logic [hfsl_pkg::SYM_W-1:0]       o_first_symbol,
    output logic [hfsl_pkg::PORT_FREQ_W-1:0] o_first_frequency,
    output logic                             o_first_is_leaf,
    output logic [hfsl_pkg::SYM_W-1:0]       o_second_symbol,
    output logic [hfsl_pkg::PORT_FREQ_W-1:0] o_second_frequency,
    output logic                             o_second_is_leaf,
    output logic [hfsl_pkg::HELD_W-1:0]      o_entries_held,
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [hfsl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [hfsl_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import hfsl_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = SYM_W + 1 + FREQ_BITS;
    localparam logic [FREQ_BITS-1:0] FREQ_MAX = {FREQ_BITS{1'b1}};
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ENTRIES);

    // sequencer states
    localparam int SW = 2;
    localparam logic [SW-1:0] S_IDLE = 2'd0;
    localparam logic [SW-1:0] S_LOOK = 2'd1;   // symbol search from the head
    localparam logic [SW-1:0] S_SINK = 2'd2;   // move entry tailward
    localparam logic [SW-1:0] S_TAKE = 2'd3;   // read the two head entries

    logic [SW-1:0]          r_state, n_state;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [CW-1:0]          r_rd_idx, n_rd_idx;
    logic                   r_rd_vld, n_rd_vld;
    logic [CW-1:0]          r_dat_idx, n_dat_idx;
    logic [CW-1:0]          r_pos, n_pos;
    logic [SYM_W-1:0]       r_mv_sym, n_mv_sym;
    logic                   r_mv_leaf, n_mv_leaf;
    logic [FREQ_BITS-1:0]   r_mv_freq, n_mv_freq;
    logic [SYM_W-1:0]       r_special;
    logic [PORT_FREQ_W-1:0] r_marker;

    // result registers
    logic                   r_done, n_done;
    logic [STATUS_W-1:0]    r_status, n_status;
    logic [SYM_W-1:0]       r_e_sym, n_e_sym;
    logic [PORT_FREQ_W-1:0] r_e_freq, n_e_freq;
    logic                   r_e_leaf, n_e_leaf;
    logic [SYM_W-1:0]       r_f_sym, n_f_sym;
    logic [PORT_FREQ_W-1:0] r_f_freq, n_f_freq;
    logic                   r_f_leaf, n_f_leaf;
    logic [SYM_W-1:0]       r_s_sym, n_s_sym;
    logic [PORT_FREQ_W-1:0] r_s_freq, n_s_freq;
    logic                   r_s_leaf, n_s_leaf;
    logic [HELD_W-1:0]      r_held, n_held;

    // ring store port
    logic [HOP_W-1:0]       head_op;
    logic                   rd_en;
    logic [EW-1:0]          rd_data;
    logic                   wr_en;
    logic [CW-1:0]          wr_idx;
    logic [EW-1:0]          wr_data;

    logic [SYM_W-1:0]       d_sym;
    logic                   d_leaf;
    logic [FREQ_BITS-1:0]   d_freq;
    logic [CW-1:0]          rd_limit;
    logic                   issue;
    logic                   special;
    logic                   do_insert;
    logic                   do_full;

    hfsl_ring #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ENTRY_W     (EW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head_op (head_op),
        .i_rd_en   (rd_en),
        .i_rd_idx  (r_rd_idx[AW-1:0]),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_idx  (wr_idx[AW-1:0]),
        .i_wr_data (wr_data)
    );

    // entry layout: symbol, leaf mark, frequency
    assign d_sym  = rd_data[EW-1 -: SYM_W];
    assign d_leaf = rd_data[FREQ_BITS];
    assign d_freq = rd_data[FREQ_BITS-1:0];

    assign special  = (i_symbol == r_special) && (i_frequency != r_marker);
    assign rd_limit = (r_state == S_TAKE) ? CW'(2) : r_cnt;
    // reads stream one position a cycle while a walk is running, up to the read limit
    assign issue    = (r_state != S_IDLE) && (r_rd_idx < rd_limit);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_pos     = r_pos;
        n_mv_sym  = r_mv_sym;
        n_mv_leaf = r_mv_leaf;
        n_mv_freq = r_mv_freq;
        rd_en     = issue;
        n_rd_idx  = r_rd_idx + CW'(issue);
        n_rd_vld  = issue;
        n_dat_idx = r_rd_idx;
        head_op   = HOP_HOLD;
        wr_en     = 1'b0;
        wr_idx    = r_pos;
        wr_data   = {r_mv_sym, r_mv_leaf, r_mv_freq};
        do_insert = 1'b0;
        do_full   = 1'b0;

        n_done   = 1'b0;
        n_status = r_status;
        n_e_sym  = r_e_sym;
        n_e_freq = r_e_freq;
        n_e_leaf = r_e_leaf;
        n_f_sym  = r_f_sym;
        n_f_freq = r_f_freq;
        n_f_leaf = r_f_leaf;
        n_s_sym  = r_s_sym;
        n_s_freq = r_s_freq;
        n_s_leaf = r_s_leaf;
        n_held   = r_held;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_rd_idx = '0;
                    if (i_cmd == CMD_TAKE) begin
                        if (r_cnt < CW'(2)) begin
                            n_done   = 1'b1;
                            n_status = ST_FEW;
                            n_e_sym  = '0;
                            n_e_freq = '0;
                            n_e_leaf = 1'b0;
                            n_f_sym  = '0;
                            n_f_freq = '0;
                            n_f_leaf = 1'b0;
                            n_s_sym  = '0;
                            n_s_freq = '0;
                            n_s_leaf = 1'b0;
                            n_held   = HELD_W'(r_cnt);
                        end else begin
                            n_state = S_TAKE;
                        end
                    end else begin
                        n_mv_sym  = i_symbol;
                        n_mv_leaf = !special;
                        n_mv_freq = FREQ_BITS'(i_frequency);
                        // merged entries and an empty table skip the search
                        if (special || (r_cnt == '0)) begin
                            if (r_cnt >= CNT_MAX) begin
                                do_full = 1'b1;
                            end else begin
                                do_insert = 1'b1;
                            end
                        end else begin
                            n_state = S_LOOK;
                        end
                    end
                end
            end
            S_LOOK: begin
                if (r_rd_vld) begin
                    if (d_sym == r_mv_sym) begin
                        // hit nearest the head: saturating increment, then sink
                        n_mv_sym  = d_sym;
                        n_mv_leaf = d_leaf;
                        n_mv_freq = (d_freq == FREQ_MAX) ? d_freq : d_freq + FREQ_BITS'(1);
                        n_pos     = r_dat_idx;
                        rd_en     = 1'b0;
                        n_rd_idx  = r_dat_idx + CW'(1);
                        n_rd_vld  = 1'b0;
                        n_state   = S_SINK;
                    end else if (r_dat_idx == r_cnt - CW'(1)) begin
                        if (r_cnt >= CNT_MAX) begin
                            do_full = 1'b1;
                        end else begin
                            do_insert = 1'b1;
                        end
                    end
                end
            end
            S_SINK: begin
                if (r_rd_vld && (d_freq < r_mv_freq)) begin
                    // smaller neighbour shifts one place toward the head
                    wr_en   = 1'b1;
                    wr_idx  = r_pos;
                    wr_data = rd_data;
                    n_pos   = r_pos + CW'(1);
                end else if (r_rd_vld || ((r_pos + CW'(1)) >= r_cnt)) begin
                    // final place found, drop the read in flight
                    wr_en    = 1'b1;
                    rd_en    = 1'b0;
                    n_rd_vld = 1'b0;
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_status = ST_OK;
                    n_e_sym  = r_mv_sym;
                    n_e_freq = PORT_FREQ_W'(r_mv_freq);
                    n_e_leaf = r_mv_leaf;
                    n_f_sym  = '0;
                    n_f_freq = '0;
                    n_f_leaf = 1'b0;
                    n_s_sym  = '0;
                    n_s_freq = '0;
                    n_s_leaf = 1'b0;
                    n_held   = HELD_W'(r_cnt);
                end
            end
            S_TAKE: begin
                if (r_rd_vld) begin
                    if (r_dat_idx == '0) begin
                        n_mv_sym  = d_sym;
                        n_mv_leaf = d_leaf;
                        n_mv_freq = d_freq;
                    end else begin
                        head_op  = HOP_ADV2;
                        n_cnt    = r_cnt - CW'(2);
                        n_state  = S_IDLE;
                        n_done   = 1'b1;
                        n_status = ST_OK;
                        n_e_sym  = '0;
                        n_e_freq = '0;
                        n_e_leaf = 1'b0;
                        n_f_sym  = r_mv_sym;
                        n_f_freq = PORT_FREQ_W'(r_mv_freq);
                        n_f_leaf = r_mv_leaf;
                        n_s_sym  = d_sym;
                        n_s_freq = PORT_FREQ_W'(d_freq);
                        n_s_leaf = d_leaf;
                        n_held   = HELD_W'(r_cnt - CW'(2));
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // new entry goes in front of the head, then sinks from position zero
        if (do_insert) begin
            head_op  = HOP_BACK;
            n_cnt    = r_cnt + CW'(1);
            n_pos    = '0;
            rd_en    = 1'b0;
            n_rd_idx = CW'(1);
            n_rd_vld = 1'b0;
            n_state  = S_SINK;
        end

        if (do_full) begin
            rd_en    = 1'b0;
            n_rd_vld = 1'b0;
            n_state  = S_IDLE;
            n_done   = 1'b1;
            n_status = ST_FULL;
            n_e_sym  = '0;
            n_e_freq = '0;
            n_e_leaf = 1'b0;
            n_f_sym  = '0;
            n_f_freq = '0;
            n_f_leaf = 1'b0;
            n_s_sym  = '0;
            n_s_freq = '0;
            n_s_leaf = 1'b0;
            n_held   = HELD_W'(r_cnt);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_rd_vld  <= 1'b0;
            r_done    <= 1'b0;
            r_special <= '0;
            r_marker  <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_rd_vld <= n_rd_vld;
            r_done   <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SPECIAL_SYMBOL:   r_special <= i_cfg_data[SYM_W-1:0];
                    CFG_MARKER_FREQUENCY: r_marker  <= i_cfg_data[PORT_FREQ_W-1:0];
                    default: begin
                        r_special <= r_special;
                    end
                endcase
            end
        end
    end

    // walk and result payload
    always_ff @(posedge i_clk) begin
        r_rd_idx  <= n_rd_idx;
        r_dat_idx <= n_dat_idx;
        r_pos     <= n_pos;
        r_mv_sym  <= n_mv_sym;
        r_mv_leaf <= n_mv_leaf;
        r_mv_freq <= n_mv_freq;
        r_status  <= n_status;
        r_e_sym   <= n_e_sym;
        r_e_freq  <= n_e_freq;
        r_e_leaf  <= n_e_leaf;
        r_f_sym   <= n_f_sym;
        r_f_freq  <= n_f_freq;
        r_f_leaf  <= n_f_leaf;
        r_s_sym   <= n_s_sym;
        r_s_freq  <= n_s_freq;
        r_s_leaf  <= n_s_leaf;
        r_held    <= n_held;
    end

    assign busy               = (r_state != S_IDLE);
    assign o_cfg_ready        = 1'b1;
    assign o_done             = r_done;
    assign o_status           = r_status;
    assign o_entry_symbol     = r_e_sym;
    assign o_entry_frequency  = r_e_freq;
    assign o_entry_is_leaf    = r_e_leaf;
    assign o_first_symbol     = r_f_sym;
    assign o_first_frequency  = r_f_freq;
    assign o_first_is_leaf    = r_f_leaf;
    assign o_second_symbol    = r_s_sym;
    assign o_second_frequency = r_s_freq;
    assign o_second_is_leaf   = r_s_leaf;
    assign o_entries_held     = r_held;

    `HFSL_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CNT_MAX, "entry count beyond table depth")
    `HFSL_ASSERT(a_sink_pos, i_clk, i_rst_n, (r_state == S_SINK) |-> (r_pos < r_cnt), "sinking entry outside held range")
    `HFSL_ASSERT(a_full_cnt, i_clk, i_rst_n, (o_done && (o_status == ST_FULL)) |-> (o_entries_held == HELD_W'(MAX_ENTRIES)), "full reported with room left")
    `HFSL_ASSERT(a_few_cnt, i_clk, i_rst_n, (o_done && (o_status == ST_FEW)) |-> (o_entries_held < HELD_W'(2)), "too few reported with two or more held")

endmodule
